// ===== rtl/core/ppp_pkg.sv =====
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared constants, types and the divider step for the point projector.
// ----------------------------------------------------------------------------
`default_nettype none

package ppp_pkg;

  localparam int PIXEL_BITS = 12;
  localparam int PBW        = $clog2(PIXEL_BITS);
  localparam int SCALE_FRAC = 16;
  localparam int XW         = 31;                     // forward distance below view range
  localparam int DW         = XW + SCALE_FRAC + 1;    // divisor 2*x scaled
  localparam int NW         = DW + PIXEL_BITS;        // dividend, quotient below 2^PIXEL_BITS

  typedef enum logic [2:0] {
    REG_ORIENT,
    REG_CAM_X,
    REG_CAM_Y,
    REG_CAM_Z,
    REG_RANGE,
    REG_COS,
    REG_SCALES,
    REG_SIZE
  } cfg_reg_t;

  // one item in the divider pipeline, column in lane 0 and row in lane 1
  typedef struct packed {
    logic                             vld;
    logic                             keep;
    logic [23:0]                      color;
    logic [DW-1:0]                    dd;
    logic [1:0][NW-1:0]               rem;
    logic [1:0][PIXEL_BITS-1:0]       q;
  } dv_t;

  // one restoring quotient bit for both lanes
  function automatic dv_t div_step(dv_t a, logic [PBW-1:0] b);
    dv_t           r;
    logic [NW-1:0] sub;
    r   = a;
    sub = NW'(a.dd) << b;
    for (int i = 0; i < 2; i++) begin
      if (a.rem[i] >= sub) begin
        r.rem[i]  = a.rem[i] - sub;
        r.q[i][b] = 1'b1;
      end
    end
    return r;
  endfunction

  // round half up from Q.28 to Q.14
  function automatic logic signed [19:0] rnd14(logic signed [34:0] s);
    logic signed [34:0] t;
    t = s + 35'sd8192;
    return t[33:14];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ppp_div.sv =====
// ----------------------------------------------------------------------------
// ppp_div
// Pipelined restoring divider, one quotient bit per stage, two lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module ppp_div
  import ppp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire dv_t  din,
  output dv_t       dout
);

  dv_t st [PIXEL_BITS];

  for (genvar k = 0; k < PIXEL_BITS; k++) begin : g_stage
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) begin
          st[k].vld <= 1'b0;
        end else if (en) begin
          st[k] <= div_step(din, PBW'(PIXEL_BITS - 1 - k));
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (rst) begin
          st[k].vld <= 1'b0;
        end else if (en) begin
          st[k] <= div_step(st[k-1], PBW'(PIXEL_BITS - 1 - k));
        end
      end
    end
  end

  assign dout = st[PIXEL_BITS-1];

endmodule

`default_nettype wire

// ===== rtl/core/perspective_point_projector_unit.sv =====
// ----------------------------------------------------------------------------
// perspective_point_projector_unit
// Pinhole projection of light points: translate, rotate, cull, project.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  cfg       cfg_valid/cfg_ready  cfg_index, cfg_data
//  in        in_valid/in_ready    point_x/y/z, point_color, on_own_body, occluded
//  out       out_valid/out_ready  blob_color, pixel_column, pixel_row
//
// one point enters per cycle while in_ready is high; the path is 11 arithmetic
// stages plus one stage per pixel bit in the divider, then the output register
// the pipeline stops only when its last stage holds a point and the output
// register is full and not taken; in_ready is low after a config transfer
// while the rotation matrix is rebuilt
// reset clears the configuration registers and all valid bits
// ----------------------------------------------------------------------------
`default_nettype none

module perspective_point_projector_unit
  import ppp_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [2:0]                   cfg_index,
  input  wire logic [63:0]                  cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [31:0]           point_x,
  input  wire logic signed [31:0]           point_y,
  input  wire logic signed [31:0]           point_z,
  input  wire logic [23:0]                  point_color,
  input  wire logic                         on_own_body,
  input  wire logic                         occluded,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [23:0]                       blob_color,
  output logic [PIXEL_BITS-1:0]             pixel_column,
  output logic [PIXEL_BITS-1:0]             pixel_row
);

  localparam int RW  = 42;
  localparam int AW  = 41;
  localparam int ALW = 21;
  localparam int AHW = AW - ALW;
  localparam int SQW = 2 * AW;
  localparam int PW  = 32 + AW;
  localparam int BW  = PIXEL_BITS + 1 + XW;
  localparam int TW  = BW + SCALE_FRAC + 1;
  localparam int NSW = TW + 2;
  localparam int LW  = SQW + 2;
  localparam int CW  = LW / 3;
  localparam int APW = CW + 32;
  localparam int RHW = APW + 2 * CW;

  // configuration registers
  logic [63:0]                 orient;
  logic signed [31:0]          cam [3];
  logic [XW-1:0]               view_range;
  logic [15:0]                 cos_ap;
  logic [63:0]                 scales;
  logic [2*PIXEL_BITS-1:0]     img;
  logic [1:0]                  settle;

  // derived from configuration
  logic signed [31:0]          qp [10];
  logic signed [19:0]          mat [3][3];
  logic [31:0]                 cos2;
  logic signed [15:0]          qw, qx, qy, qz;
  logic [31:0]                 scl [2];
  logic [PIXEL_BITS-1:0]       size [2];

  logic                        en, in_acc;
  logic [10:0]                 v;
  logic [23:0]                 col_sr [11];

  // stage registers
  logic signed [32:0]          s1_d [3];
  logic                        s1_drop, s2_drop, s3_drop, s4_drop;
  logic signed [36:0]          s2_pl [3][3];
  logic signed [36:0]          s2_ph [3][3];
  logic signed [53:0]          s3_p [3][3];
  logic signed [RW-1:0]        s4_r [3];
  logic signed [55:0]          rsum [3];
  logic                        s5_pass, s6_pass, s7_pass, s8_pass, s9_pass, s10_pass;
  logic                        s11_keep;
  logic [XW-1:0]               s5_x, s6_x, s7_x, s8_x;
  logic [AW-1:0]               s5_a [2];
  logic                        s5_s [2], s6_s [2], s7_s [2];
  logic [2*XW-1:0]             s6_x2, s7_x2, s8_x2, s9_x2, s10_x2;
  logic [2*AHW-1:0]            s6_hh [2];
  logic [AW-1:0]               s6_hl [2];
  logic [2*ALW-1:0]            s6_ll [2];
  logic [32+AHW-1:0]           s6_ph [2];
  logic [32+ALW-1:0]           s6_pl [2];
  logic [BW-1:0]               s6_bw [2], s6_ww [2], s7_bw [2], s7_ww [2];
  logic [SQW-1:0]              s7_sq [2];
  logic [PW-1:0]               s7_p [2];
  logic [LW-1:0]               s8_len2;
  logic                        s8_ok [2], s9_ok [2], s10_ok [2];
  logic signed [NSW-1:0]       s8_n [2];
  logic [NW-1:0]               s9_nf [2], s10_nf [2], s11_nf [2];
  logic [DW-1:0]               s9_dd, s10_dd, s11_dd;
  logic [APW-1:0]              s9_a [3];
  logic [RHW-1:0]              s10_rhs;

  // combinational helpers
  logic [PW:0]                 twop [2];
  logic [PW:0]                 bnd [2];
  logic [BW+SCALE_FRAC-1:0]    wd [2];
  logic [TW-1:0]               tv [2];
  logic signed [NSW-1:0]       nv [2];
  logic [NSW:0]                nd [2];
  logic [DW-1:0]               dd8;
  logic                        ok9 [2];

  dv_t                         din, dout;

  assign qw = orient[15:0];
  assign qx = orient[31:16];
  assign qy = orient[47:32];
  assign qz = orient[63:48];
  assign scl[0]  = scales[31:0];
  assign scl[1]  = scales[63:32];
  assign size[0] = img[PIXEL_BITS-1:0];
  assign size[1] = img[2*PIXEL_BITS-1:PIXEL_BITS];

  assign cfg_ready = 1'b1;
  assign en        = !(dout.vld && out_valid && !out_ready);
  assign in_ready  = en && (settle == 2'd0);
  assign in_acc    = in_valid && in_ready;

  // configuration transfers and control
  always_ff @(posedge clk) begin
    if (rst) begin
      orient     <= '0;
      cam[0]     <= '0;
      cam[1]     <= '0;
      cam[2]     <= '0;
      view_range <= '0;
      cos_ap     <= '0;
      scales     <= '0;
      img        <= '0;
      settle     <= 2'd2;
      v          <= '0;
    end else begin
      if (cfg_valid) begin
        settle <= 2'd2;
        case (cfg_index)
          REG_ORIENT: orient     <= cfg_data;
          REG_CAM_X:  cam[0]     <= cfg_data[31:0];
          REG_CAM_Y:  cam[1]     <= cfg_data[31:0];
          REG_CAM_Z:  cam[2]     <= cfg_data[31:0];
          REG_RANGE:  view_range <= cfg_data[XW-1:0];
          REG_COS:    cos_ap     <= cfg_data[15:0];
          REG_SCALES: scales     <= cfg_data;
          REG_SIZE:   img        <= cfg_data[2*PIXEL_BITS-1:0];
          default: ;
        endcase
      end else if (settle != 2'd0) begin
        settle <= settle - 2'd1;
      end
      if (en) begin
        v <= {v[9:0], in_acc};
      end
    end
  end

  // rotation matrix from the quaternion, products then rounded sums, and the squared aperture cosine
  always_ff @(posedge clk) begin
    qp[0] <= qw * qw;
    qp[1] <= qx * qx;
    qp[2] <= qy * qy;
    qp[3] <= qz * qz;
    qp[4] <= qx * qy;
    qp[5] <= qw * qz;
    qp[6] <= qx * qz;
    qp[7] <= qw * qy;
    qp[8] <= qy * qz;
    qp[9] <= qw * qx;
    cos2  <= cos_ap * cos_ap;
    mat[0][0] <= rnd14(35'(qp[0]) + 35'(qp[1]) - 35'(qp[2]) - 35'(qp[3]));
    mat[0][1] <= rnd14((35'(qp[4]) - 35'(qp[5])) <<< 1);
    mat[0][2] <= rnd14((35'(qp[6]) + 35'(qp[7])) <<< 1);
    mat[1][0] <= rnd14((35'(qp[4]) + 35'(qp[5])) <<< 1);
    mat[1][1] <= rnd14(35'(qp[0]) - 35'(qp[1]) + 35'(qp[2]) - 35'(qp[3]));
    mat[1][2] <= rnd14((35'(qp[8]) - 35'(qp[9])) <<< 1);
    mat[2][0] <= rnd14((35'(qp[6]) - 35'(qp[7])) <<< 1);
    mat[2][1] <= rnd14((35'(qp[8]) + 35'(qp[9])) <<< 1);
    mat[2][2] <= rnd14(35'(qp[0]) - 35'(qp[1]) - 35'(qp[2]) + 35'(qp[3]));
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rsum[i] = 56'(s3_p[i][0]) + 56'(s3_p[i][1]) + 56'(s3_p[i][2]) + 56'sd8192;
    end
    for (int a = 0; a < 2; a++) begin
      twop[a] = {s7_p[a], 1'b0};
      bnd[a]  = (PW+1)'({s7_bw[a], {SCALE_FRAC{1'b0}}});
      wd[a]   = {s7_ww[a], {SCALE_FRAC{1'b0}}};
      tv[a]   = twop[a][TW-1:0];
      nv[a]   = s7_s[a] ? (NSW'(wd[a]) - NSW'(tv[a])) : (NSW'(wd[a]) + NSW'(tv[a]));
    end
    dd8 = {s8_x, {(SCALE_FRAC+1){1'b0}}};
    for (int a = 0; a < 2; a++) begin
      nd[a]  = (NSW+1)'(s8_n[a]) + (NSW+1)'(dd8);
      // a small negative numerator still truncates to pixel zero
      ok9[a] = s8_ok[a] && (!s8_n[a][NSW-1] || (!nd[a][NSW] && nd[a] != '0));
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      col_sr[0] <= point_color;
      for (int k = 1; k < 11; k++) begin
        col_sr[k] <= col_sr[k-1];
      end

      // stage 1: relative vector
      for (int j = 0; j < 3; j++) begin
        s1_d[j] <= 33'(j == 0 ? point_x : (j == 1 ? point_y : point_z)) - 33'(cam[j]);
      end
      s1_drop <= (point_color == '0) || on_own_body || occluded;

      // stage 2: half products of the rotation
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s2_pl[i][j] <= mat[i][j] * $signed({1'b0, s1_d[j][15:0]});
          s2_ph[i][j] <= mat[i][j] * $signed(s1_d[j][32:16]);
        end
      end
      s2_drop <= s1_drop;

      // stage 3: full products
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s3_p[i][j] <= (54'(s2_ph[i][j]) <<< 16) + 54'(s2_pl[i][j]);
        end
      end
      s3_drop <= s2_drop;

      // stage 4: rounded rotated components
      for (int i = 0; i < 3; i++) begin
        s4_r[i] <= rsum[i][55:14];
      end
      s4_drop <= s3_drop;

      // stage 5: range test and magnitudes
      s5_pass <= !s4_drop && (s4_r[0] > 42'sd0) && (s4_r[0] < $signed({11'b0, view_range}));
      s5_x    <= s4_r[0][XW-1:0];
      for (int a = 0; a < 2; a++) begin
        s5_a[a] <= s4_r[a+1][RW-1] ? AW'(-s4_r[a+1]) : s4_r[a+1][AW-1:0];
        s5_s[a] <= !s4_r[a+1][RW-1];
      end

      // stage 6: squares, scale products and image bounds
      s6_x2   <= s5_x * s5_x;
      s6_x    <= s5_x;
      s6_pass <= s5_pass;
      for (int a = 0; a < 2; a++) begin
        s6_hh[a] <= s5_a[a][AW-1:ALW] * s5_a[a][AW-1:ALW];
        s6_hl[a] <= s5_a[a][AW-1:ALW] * s5_a[a][ALW-1:0];
        s6_ll[a] <= s5_a[a][ALW-1:0] * s5_a[a][ALW-1:0];
        s6_ph[a] <= scl[a] * s5_a[a][AW-1:ALW];
        s6_pl[a] <= scl[a] * s5_a[a][ALW-1:0];
        s6_bw[a] <= BW'({1'b0, size[a]} + (PIXEL_BITS+1)'(2)) * BW'(s5_x);
        s6_ww[a] <= BW'(size[a]) * BW'(s5_x);
        s6_s[a]  <= s5_s[a];
      end

      // stage 7: assemble squares and scaled components
      s7_x2   <= s6_x2;
      s7_x    <= s6_x;
      s7_pass <= s6_pass;
      for (int a = 0; a < 2; a++) begin
        s7_sq[a] <= (SQW'(s6_hh[a]) << (2 * ALW)) + (SQW'(s6_hl[a]) << (ALW + 1))
                    + SQW'(s6_ll[a]);
        s7_p[a]  <= (PW'(s6_ph[a]) << ALW) + PW'(s6_pl[a]);
        s7_bw[a] <= s6_bw[a];
        s7_ww[a] <= s6_ww[a];
        s7_s[a]  <= s6_s[a];
      end

      // stage 8: length squared, bound test, numerator
      s8_len2 <= LW'(s7_x2) + LW'(s7_sq[0]) + LW'(s7_sq[1]);
      s8_x2   <= s7_x2;
      s8_x    <= s7_x;
      s8_pass <= s7_pass;
      for (int a = 0; a < 2; a++) begin
        s8_ok[a] <= twop[a] < bnd[a];
        s8_n[a]  <= nv[a];
      end

      // stage 9: aperture partial products, numerator sign handling
      for (int c = 0; c < 3; c++) begin
        s9_a[c] <= s8_len2[c*CW +: CW] * cos2;
      end
      s9_x2   <= s8_x2;
      s9_dd   <= dd8;
      s9_pass <= s8_pass;
      for (int a = 0; a < 2; a++) begin
        s9_ok[a] <= ok9[a];
        s9_nf[a] <= s8_n[a][NSW-1] ? '0 : s8_n[a][NW-1:0];
      end

      // stage 10: cos^2 * |v|^2
      s10_rhs  <= RHW'(s9_a[0]) + (RHW'(s9_a[1]) << CW) + (RHW'(s9_a[2]) << (2 * CW));
      s10_x2   <= s9_x2;
      s10_dd   <= s9_dd;
      s10_pass <= s9_pass;
      s10_ok   <= s9_ok;
      s10_nf   <= s9_nf;

      // stage 11: aperture compare
      s11_keep <= s10_pass && s10_ok[0] && s10_ok[1]
                  && (s10_rhs < (RHW'(s10_x2) << 32));
      s11_dd   <= s10_dd;
      s11_nf   <= s10_nf;
    end
  end

  always_comb begin
    din.vld    = v[10];
    din.keep   = s11_keep;
    din.color  = col_sr[10];
    din.dd     = s11_dd;
    din.rem[0] = s11_nf[0];
    din.rem[1] = s11_nf[1];
    din.q      = '0;
  end

  ppp_div u_div (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .din  (din),
    .dout (dout)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= dout.vld && dout.keep && (dout.q[0] < size[0]) && (dout.q[1] < size[1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      blob_color   <= dout.color;
      pixel_column <= dout.q[0];
      pixel_row    <= dout.q[1];
    end
  end

endmodule

`default_nettype wire
